@@ sv/argon2_block_compression_macros.svh @@
// assertion helpers for the block compression design
`ifndef ARGON2_BLOCK_COMPRESSION_MACROS_SVH
`define ARGON2_BLOCK_COMPRESSION_MACROS_SVH

// property must hold on every clock edge outside reset
`define A2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define A2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/a2bc_pkg.sv @@
`default_nettype none
package a2bc_pkg;
  localparam int unsigned WORDS = 128;
  localparam int unsigned PAIRS = 64;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned ADDR_W = 7;
  localparam int unsigned PAIR_W = 6;
  localparam int unsigned QUEUE_DEPTH = 4;

  // one loaded pair, already folded as x xor y
  typedef struct packed {
    logic [PAIR_W-1:0] idx;
    logic [WORD_W-1:0] w_even;
    logic [WORD_W-1:0] w_odd;
  } pair_t;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                             input logic [5:0] n);
    rotr = (v >> n) | (v << (7'd64 - {1'b0, n}));
  endfunction

  // word index of operand k (0..3 for a,b,c,d) of mix m (0..7) in group g,
  // for the column pass (row = 0) or the row pass (row = 1)
  function automatic logic [ADDR_W-1:0] mix_addr(input logic row, input logic [2:0] g,
                                                 input logic [2:0] m, input logic [1:0] k);
    logic [3:0] p;
    logic [1:0] lane;
    logic [2:0] pos8;
    lane = m[2] ? (m[1:0] + k) : m[1:0];
    p = {k, lane};
    if (!row) begin
      mix_addr = {g, p};
    end else begin
      pos8 = p[3:1];
      mix_addr = {pos8, g, p[0]};
    end
  endfunction
endpackage
`default_nettype wire

@@ sv/argon2_block_compression.sv @@
`default_nettype none
// Argon2 block compression. Each input item carries two words of X and of Y;
// after 64 items the block R = X xor Y is compressed by eight BLAKE2 rounds
// over column groups and eight over row groups, and P(R) xor R leaves as 64
// pairs with tlast on the final one. A small queue decouples loading from the
// compute core, so loading runs at one item per cycle until the core starts.
// The core has one shared G unit: each of the 128 mixes reads its four
// operand words, runs 8 G steps and makes 4 write-backs, and the result
// then drains as 64 pairs; while a block is in the core only the queue takes
// input, so at most QUEUE_DEPTH items are accepted before the drain ends.
module argon2_block_compression #(
  parameter int unsigned QUEUE_DEPTH = a2bc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output      logic          in_tready,
  input  wire logic [255:0]  in_tdata,   // x_even, x_odd, y_even, y_odd
  output      logic          out_tvalid,
  input  wire logic          out_tready,
  output      logic [127:0]  out_tdata,  // out_even, out_odd
  output      logic          out_tlast   // last_pair
);
  logic q_valid, q_ready;
  a2bc_pkg::pair_t q_data;

  a2bc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_ready, .q_data
  );

  a2bc_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );
endmodule
`default_nettype wire

@@ sv/a2bc_front.sv @@
`default_nettype none
// accepts load items, folds x xor y and tags each with its pair index
module a2bc_front #(
  parameter int unsigned DEPTH = a2bc_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  input  wire logic [4*a2bc_pkg::WORD_W-1:0] in_tdata,
  output      logic                         q_valid,
  input  wire logic                         q_ready,
  output      a2bc_pkg::pair_t              q_data
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  a2bc_pkg::pair_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  logic [a2bc_pkg::PAIR_W-1:0] idx_r;
  logic push, pop;

  assign in_tready = (cnt_r != DEPTH[PW:0]);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].idx <= idx_r;
      mem_r[wp_r].w_even <= in_tdata[63:0] ^ in_tdata[191:128];
      mem_r[wp_r].w_odd <= in_tdata[127:64] ^ in_tdata[255:192];
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
        idx_r <= idx_r + 1'b1;
      end
      if (pop) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

@@ sv/a2bc_back.sv @@
`default_nettype none
`include "argon2_block_compression_macros.svh"
// stores the block, runs the 128 mixes with one shared g unit, drains result
module a2bc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  output      logic                          q_ready,
  input  wire a2bc_pkg::pair_t               q_data,
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  output      logic [2*a2bc_pkg::WORD_W-1:0] out_tdata,
  output      logic                          out_tlast
);
  typedef enum logic [2:0] {S_LOAD, S_RD, S_G, S_WR, S_OUT} state_t;
  state_t state_r;

  logic [a2bc_pkg::WORD_W-1:0] work_r [a2bc_pkg::WORDS];
  logic [a2bc_pkg::WORD_W-1:0] save_r [a2bc_pkg::WORDS];

  logic row_r;
  logic [2:0] grp_r, mix_r;
  logic [1:0] k_r;
  logic [2:0] step_r;
  logic [a2bc_pkg::WORD_W-1:0] a_r, b_r, c_r, d_r;
  logic [a2bc_pkg::PAIR_W-1:0] oidx_r;
  logic [a2bc_pkg::WORD_W-1:0] rd_r;
  logic [a2bc_pkg::ADDR_W-1:0] addr;
  logic load_last;

  assign q_ready = (state_r == S_LOAD);
  assign load_last = q_valid && q_ready && (q_data.idx == '1);
  // the drain shares the mix read port for the even word
  assign addr = (state_r == S_OUT) ? {oidx_r, 1'b0}
                                   : a2bc_pkg::mix_addr(row_r, grp_r, mix_r, k_r);

  always_ff @(posedge clk) begin
    rd_r <= work_r[addr];
    if (q_valid && q_ready) begin
      work_r[{q_data.idx, 1'b0}] <= q_data.w_even;
      work_r[{q_data.idx, 1'b1}] <= q_data.w_odd;
      save_r[{q_data.idx, 1'b0}] <= q_data.w_even;
      save_r[{q_data.idx, 1'b1}] <= q_data.w_odd;
    end
    if (state_r == S_G) begin
      unique case (step_r)
        3'd0: a_r <= a_r + b_r;
        3'd1: d_r <= a2bc_pkg::rotr(d_r ^ a_r, 6'd32);
        3'd2: c_r <= c_r + d_r;
        3'd3: b_r <= a2bc_pkg::rotr(b_r ^ c_r, 6'd24);
        3'd4: a_r <= a_r + b_r;
        3'd5: d_r <= a2bc_pkg::rotr(d_r ^ a_r, 6'd16);
        3'd6: c_r <= c_r + d_r;
        default: b_r <= a2bc_pkg::rotr(b_r ^ c_r, 6'd63);
      endcase
    end
    if (state_r == S_RD && step_r[0]) begin
      unique case (k_r)
        2'd0: a_r <= rd_r;
        2'd1: b_r <= rd_r;
        2'd2: c_r <= rd_r;
        default: d_r <= rd_r;
      endcase
    end
    if (state_r == S_WR) begin
      unique case (k_r)
        2'd0: work_r[addr] <= a_r;
        2'd1: work_r[addr] <= b_r;
        2'd2: work_r[addr] <= c_r;
        default: work_r[addr] <= d_r;
      endcase
    end
    if (state_r == S_OUT && (!out_tvalid || out_tready)) begin
      out_tdata <= {work_r[{oidx_r, 1'b1}] ^ save_r[{oidx_r, 1'b1}],
                    work_r[addr] ^ save_r[{oidx_r, 1'b0}]};
      out_tlast <= (oidx_r == '1);
    end
    if (!rst_n) begin
      state_r <= S_LOAD;
      out_tvalid <= 1'b0;
      row_r <= 1'b0; grp_r <= '0; mix_r <= '0; k_r <= '0; step_r <= '0;
      oidx_r <= '0;
    end else begin
      if (state_r == S_OUT && (!out_tvalid || out_tready)) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_LOAD: if (load_last) begin
          state_r <= S_RD;
          row_r <= 1'b0; grp_r <= '0; mix_r <= '0; k_r <= '0; step_r <= '0;
        end
        S_RD: begin
          // step 0 addresses the store, step 1 captures the word
          if (!step_r[0]) step_r <= 3'd1;
          else begin
            step_r <= '0;
            k_r <= k_r + 1'b1;
            if (k_r == 2'd3) state_r <= S_G;
          end
        end
        S_G: begin
          step_r <= step_r + 1'b1;
          if (step_r == 3'd7) state_r <= S_WR;
        end
        S_WR: begin
          k_r <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            mix_r <= mix_r + 1'b1;
            // last mix of the last row group starts the drain
            if (row_r && mix_r == 3'd7 && grp_r == 3'd7) begin
              state_r <= S_OUT;
              oidx_r <= '0;
            end else begin
              state_r <= S_RD;
            end
            if (mix_r == 3'd7) begin
              grp_r <= grp_r + 1'b1;
              if (grp_r == 3'd7) row_r <= 1'b1;
            end
          end
        end
        default: if (!out_tvalid || out_tready) begin
          oidx_r <= oidx_r + 1'b1;
          if (oidx_r == '1) state_r <= S_LOAD;
        end
      endcase
    end
  end

  `A2_ASSERT(a_ready_only_load, !(q_ready && state_r != S_LOAD), "ready outside load")
  `A2_ASSERT_NEXT(a_last_to_rd, load_last, state_r == S_RD, "missed block start")
  `A2_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                  "result dropped")
endmodule
`default_nettype wire
